FILE: src/rerp_pkg.sv
// Shared types and constants of the recency-excluding random picker.
package rerp_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int ENTRY_BITS_DEF  = 16;
   localparam int RAND_W          = 32;
   localparam int CFG_W           = 7;
   localparam int ACT_W           = 3;

   localparam logic [CFG_W-1:0] MAX_IGNORE_RESET = 7'd4;

   localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_APPEND = 3'd1;
   localparam logic [ACT_W-1:0] ACT_PICK   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_ACCEPT = 3'd3;
   localparam logic [ACT_W-1:0] ACT_REJECT = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_PICK_CAP,
      ST_SW_B,
      ST_SW_C,
      ST_SW_D,
      ST_ROT_CHECK,
      ST_ROT_SAVE,
      ST_ROT_SHIFT,
      ST_ROT_TAIL,
      ST_RESP
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_APPEND,
      OP_FAIL,
      OP_DIV_START,
      OP_PICK_READ,
      OP_PICK_CAPTURE,
      OP_SW_READ_POS,
      OP_SW_READ_PART,
      OP_SW_WRITE_POS,
      OP_SW_WRITE_PART,
      OP_ROT_READ_HEAD,
      OP_ROT_SAVE,
      OP_ROT_SHIFT,
      OP_ROT_TAIL,
      OP_ROT_DEC
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             append_ok;
      logic             avail_nz;
      logic             pos_ok;
      logic             div_busy;
      logic             rot_needed;
      logic             rot_single;
      logic             rot_last;
   } dp_status_type;

endpackage

FILE: src/recency_excluding_random_picker_top.sv
// Top level of the recency-excluding random picker.
// The req channel takes one command word (clear, append, pick, accept, reject)
// per valid/ready handshake; the rsp channel returns exactly one result word
// for each, in order. Commands are handled one at a time: req_ready is high
// only while the controller is idle, and drops the cycle after an accept.
// Path of each command from the accepting edge to rsp_valid, receiver ready:
//   clear, append, failed command: decode, then the response state.
//   pick: paced by the bit-serial remainder unit (32 steps), then a table read.
//   accept: a swap of two table words, then left rotations of the recent region
//     while it exceeds max_ignore; one rotation at most unless max_ignore was
//     lowered, since an accept grows that region by one entry. Reject: the swap only.
// The next word can be taken in the cycle after the result is loaded.
// The result sits in an output register; a stalled receiver holds it there
// while the block already accepts and works on the next word, which then
// waits for the register to free up.
// Synchronous reset empties all regions and sets max_ignore to 4. Table
// contents are not cleared. csr_write_enable writes max_ignore at once and
// is meant for idle periods only.
module recency_excluding_random_picker_top #(
   parameter int TABLE_DEPTH = rerp_pkg::TABLE_DEPTH_DEF,
   parameter int ENTRY_BITS  = rerp_pkg::ENTRY_BITS_DEF,
   localparam int POS_W      = $clog2(TABLE_DEPTH),
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rerp_pkg::ACT_W-1:0]  req_action,
   input  logic [ENTRY_BITS-1:0]       req_entry_in,
   input  logic [POS_W-1:0]            req_position_in,
   input  logic [rerp_pkg::RAND_W-1:0] req_random_word,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_ok,
   output logic [POS_W-1:0]            rsp_position_out,
   output logic [ENTRY_BITS-1:0]       rsp_entry_out,
   output logic [CNT_W-1:0]            rsp_recent_count,
   output logic [CNT_W-1:0]            rsp_rejected_count,
   input  logic                        csr_write_enable,
   input  logic [rerp_pkg::CFG_W-1:0]  csr_write_data
);
   import rerp_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   rerp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rerp_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ENTRY_BITS  (ENTRY_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_action         (req_action),
      .req_entry_in       (req_entry_in),
      .req_position_in    (req_position_in),
      .req_random_word    (req_random_word),
      .rsp_ok             (rsp_ok),
      .rsp_position_out   (rsp_position_out),
      .rsp_entry_out      (rsp_entry_out),
      .rsp_recent_count   (rsp_recent_count),
      .rsp_rejected_count (rsp_rejected_count)
   );

endmodule

FILE: src/rerp_mod_unit.sv
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
module rerp_mod_unit #(
   parameter int DIVISOR_W = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rerp_pkg::RAND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]        divisor,
   output logic                        busy,
   output logic [DIVISOR_W-1:0]        remainder
);
   import rerp_pkg::*;

   localparam int STEP_W = $clog2(RAND_W + 1);

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [RAND_W-1:0]   quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [DIVISOR_W:0]  trial;
   logic [DIVISOR_W:0]  div_ext;
   logic [DIVISOR_W:0]  trial_diff;

   assign trial      = {rem_ff, quo_ff[RAND_W-1]};
   assign div_ext    = {1'b0, div_ff};
   assign trial_diff = trial - div_ext;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(RAND_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits its width.
         rem_in  = (trial >= div_ext) ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[RAND_W-2:0], 1'b0};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

FILE: src/rerp_datapath.sv
// Datapath: entry table, region counters, remainder unit and result registers.
module rerp_datapath #(
   parameter int TABLE_DEPTH = rerp_pkg::TABLE_DEPTH_DEF,
   parameter int ENTRY_BITS  = rerp_pkg::ENTRY_BITS_DEF,
   localparam int POS_W      = $clog2(TABLE_DEPTH),
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rerp_pkg::ctrl_cmd_type      cmd,
   output rerp_pkg::dp_status_type     status,
   input  logic                        csr_write_enable,
   input  logic [rerp_pkg::CFG_W-1:0]  csr_write_data,
   input  logic [rerp_pkg::ACT_W-1:0]  req_action,
   input  logic [ENTRY_BITS-1:0]       req_entry_in,
   input  logic [POS_W-1:0]            req_position_in,
   input  logic [rerp_pkg::RAND_W-1:0] req_random_word,
   output logic                        rsp_ok,
   output logic [POS_W-1:0]            rsp_position_out,
   output logic [ENTRY_BITS-1:0]       rsp_entry_out,
   output logic [CNT_W-1:0]            rsp_recent_count,
   output logic [CNT_W-1:0]            rsp_rejected_count
);
   import rerp_pkg::*;

   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   // Latched request word.
   logic [ACT_W-1:0]      act_ff, act_in;
   logic [ENTRY_BITS-1:0] ent_req_ff, ent_req_in;
   logic [POS_W-1:0]      pos_req_ff, pos_req_in;
   logic [RAND_W-1:0]     rnd_ff, rnd_in;

   logic [CFG_W-1:0]      max_ignore_ff, max_ignore_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      recent_ff, recent_in;
   logic [CNT_W-1:0]      rejected_ff, rejected_in;

   logic                  res_ok_ff, res_ok_in;
   logic [POS_W-1:0]      res_pos_ff, res_pos_in;
   logic [ENTRY_BITS-1:0] res_ent_ff, res_ent_in;
   logic [ENTRY_BITS-1:0] save_ff, save_in;
   logic [POS_W-1:0]      idx_ff, idx_in;

   logic                  rsp_ok_ff;
   logic [POS_W-1:0]      rsp_pos_ff;
   logic [ENTRY_BITS-1:0] rsp_ent_ff;
   logic [CNT_W-1:0]      rsp_recent_ff;
   logic [CNT_W-1:0]      rsp_rejected_ff;

   logic [ENTRY_BITS-1:0] entry_store [TABLE_DEPTH];
   logic [ENTRY_BITS-1:0] rd_data_ff;
   logic                  mem_we;
   logic [POS_W-1:0]      mem_waddr;
   logic [ENTRY_BITS-1:0] mem_wdata;
   logic                  mem_re;
   logic [POS_W-1:0]      mem_raddr;

   logic [CNT_W:0]        used;
   logic [CNT_W:0]        count_ext;
   logic [CNT_W:0]        avail_ext;
   logic [CNT_W-1:0]      avail;
   logic                  avail_nz;
   logic [CNT_W-1:0]      region_end;
   logic [CNT_W-1:0]      last_open;
   logic [CNT_W-1:0]      pos_ext;
   logic [POS_W-1:0]      partner;
   logic [CNT_W-1:0]      rem;
   logic                  div_busy;
   logic [CNT_W-1:0]      pick_sum;
   logic [CNT_W-1:0]      idx_plus1;
   logic [CNT_W-1:0]      idx_plus2;
   logic [CNT_W-1:0]      tail_cnt;

   assign used       = (CNT_W+1)'(recent_ff) + (CNT_W+1)'(rejected_ff);
   assign count_ext  = (CNT_W+1)'(count_ff);
   assign avail_nz   = count_ext > used;
   assign avail_ext  = count_ext - used;
   assign avail      = avail_nz ? avail_ext[CNT_W-1:0] : '0;
   assign region_end = count_ff - rejected_ff;
   assign last_open  = region_end - CNT_W'(1);
   assign pos_ext    = CNT_W'(pos_req_ff);
   assign partner    = (act_ff == ACT_ACCEPT) ? recent_ff[POS_W-1:0] : last_open[POS_W-1:0];
   assign pick_sum   = recent_ff + rem;
   assign idx_plus1  = CNT_W'(idx_ff) + CNT_W'(1);
   assign idx_plus2  = CNT_W'(idx_ff) + CNT_W'(2);
   assign tail_cnt   = recent_ff - CNT_W'(1);

   rerp_mod_unit #(
      .DIVISOR_W(CNT_W)
   ) u_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.op == OP_DIV_START),
      .dividend  (rnd_ff),
      .divisor   (avail),
      .busy      (div_busy),
      .remainder (rem)
   );

   always_comb begin
      status.action     = act_ff;
      status.append_ok  = count_ff < CNT_W'(TABLE_DEPTH);
      status.avail_nz   = avail_nz;
      status.pos_ok     = avail_nz && (pos_ext >= recent_ff) && (pos_ext < region_end);
      status.div_busy   = div_busy;
      status.rot_needed = CMP_W'(recent_ff) > CMP_W'(max_ignore_ff);
      status.rot_single = recent_ff == CNT_W'(1);
      status.rot_last   = idx_plus2 == recent_ff;
   end

   // Memory port selection.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = rd_data_ff;
      mem_re    = 1'b0;
      mem_raddr = '0;
      case (cmd.op)
         OP_APPEND: begin
            mem_we    = 1'b1;
            mem_waddr = count_ff[POS_W-1:0];
            mem_wdata = ent_req_ff;
         end
         OP_PICK_READ: begin
            mem_re    = 1'b1;
            mem_raddr = pick_sum[POS_W-1:0];
         end
         OP_SW_READ_POS: begin
            mem_re    = 1'b1;
            mem_raddr = pos_req_ff;
         end
         OP_SW_READ_PART: begin
            mem_re    = 1'b1;
            mem_raddr = partner;
         end
         OP_SW_WRITE_POS: begin
            mem_we    = 1'b1;
            mem_waddr = pos_req_ff;
            mem_wdata = rd_data_ff;
         end
         OP_SW_WRITE_PART: begin
            mem_we    = 1'b1;
            mem_waddr = partner;
            mem_wdata = res_ent_ff;
         end
         OP_ROT_READ_HEAD: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
         end
         OP_ROT_SAVE: begin
            mem_re    = 1'b1;
            mem_raddr = idx_plus1[POS_W-1:0];
         end
         OP_ROT_SHIFT: begin
            // Write the word read last cycle one slot down and fetch the next one.
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = rd_data_ff;
            mem_re    = 1'b1;
            mem_raddr = idx_plus2[POS_W-1:0];
         end
         OP_ROT_TAIL: begin
            mem_we    = 1'b1;
            mem_waddr = tail_cnt[POS_W-1:0];
            mem_wdata = save_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_store[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= entry_store[mem_raddr];
      end
   end

   always_comb begin
      act_in        = act_ff;
      ent_req_in    = ent_req_ff;
      pos_req_in    = pos_req_ff;
      rnd_in        = rnd_ff;
      max_ignore_in = max_ignore_ff;
      count_in      = count_ff;
      recent_in     = recent_ff;
      rejected_in   = rejected_ff;
      res_ok_in     = res_ok_ff;
      res_pos_in    = res_pos_ff;
      res_ent_in    = res_ent_ff;
      save_in       = save_ff;
      idx_in        = idx_ff;
      case (cmd.op)
         OP_LOAD: begin
            act_in     = req_action;
            ent_req_in = req_entry_in;
            pos_req_in = req_position_in;
            rnd_in     = req_random_word;
         end
         OP_CLEAR: begin
            count_in    = '0;
            recent_in   = '0;
            rejected_in = '0;
            res_ok_in   = 1'b1;
            res_pos_in  = '0;
            res_ent_in  = '0;
         end
         OP_APPEND: begin
            count_in   = count_ff + CNT_W'(1);
            res_ok_in  = 1'b1;
            res_pos_in = count_ff[POS_W-1:0];
            res_ent_in = ent_req_ff;
         end
         OP_FAIL: begin
            res_ok_in  = 1'b0;
            res_pos_in = '0;
            res_ent_in = '0;
         end
         OP_PICK_READ: begin
            res_pos_in = pick_sum[POS_W-1:0];
         end
         OP_PICK_CAPTURE: begin
            res_ok_in  = 1'b1;
            res_ent_in = rd_data_ff;
         end
         OP_SW_READ_POS: begin
            res_ok_in  = 1'b1;
            res_pos_in = pos_req_ff;
         end
         OP_SW_READ_PART: begin
            res_ent_in = rd_data_ff;
         end
         OP_SW_WRITE_PART: begin
            if (act_ff == ACT_ACCEPT) begin
               recent_in   = recent_ff + CNT_W'(1);
               rejected_in = '0;
            end else begin
               rejected_in = rejected_ff + CNT_W'(1);
            end
         end
         OP_ROT_READ_HEAD: begin
            idx_in = '0;
         end
         OP_ROT_SAVE: begin
            save_in = rd_data_ff;
         end
         OP_ROT_SHIFT: begin
            idx_in = idx_plus1[POS_W-1:0];
         end
         OP_ROT_TAIL, OP_ROT_DEC: begin
            recent_in = tail_cnt;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
      if (csr_write_enable) begin
         max_ignore_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ignore_ff <= MAX_IGNORE_RESET;
         count_ff      <= '0;
         recent_ff     <= '0;
         rejected_ff   <= '0;
      end else begin
         max_ignore_ff <= max_ignore_in;
         count_ff      <= count_in;
         recent_ff     <= recent_in;
         rejected_ff   <= rejected_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      ent_req_ff <= ent_req_in;
      pos_req_ff <= pos_req_in;
      rnd_ff     <= rnd_in;
      res_ok_ff  <= res_ok_in;
      res_pos_ff <= res_pos_in;
      res_ent_ff <= res_ent_in;
      save_ff    <= save_in;
      idx_ff     <= idx_in;
      if (cmd.rsp_load) begin
         rsp_ok_ff       <= res_ok_ff;
         rsp_pos_ff      <= res_pos_ff;
         rsp_ent_ff      <= res_ent_ff;
         rsp_recent_ff   <= recent_ff;
         rsp_rejected_ff <= rejected_ff;
      end
   end

   assign rsp_ok             = rsp_ok_ff;
   assign rsp_position_out   = rsp_pos_ff;
   assign rsp_entry_out      = rsp_ent_ff;
   assign rsp_recent_count   = rsp_recent_ff;
   assign rsp_rejected_count = rsp_rejected_ff;

endmodule

FILE: src/rerp_ctrl.sv
// Controller: sequences each word through the datapath and owns both handshakes.
module rerp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rerp_pkg::dp_status_type status,
   output rerp_pkg::ctrl_cmd_type  cmd
);
   import rerp_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.rsp_load = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RESP;
            case (status.action)
               ACT_CLEAR: begin
                  cmd.op = OP_CLEAR;
               end
               ACT_APPEND: begin
                  cmd.op = status.append_ok ? OP_APPEND : OP_FAIL;
               end
               ACT_PICK: begin
                  if (status.avail_nz) begin
                     cmd.op   = OP_DIV_START;
                     state_in = ST_DIV;
                  end else begin
                     cmd.op = OP_FAIL;
                  end
               end
               ACT_ACCEPT, ACT_REJECT: begin
                  if (status.pos_ok) begin
                     cmd.op   = OP_SW_READ_POS;
                     state_in = ST_SW_B;
                  end else begin
                     cmd.op = OP_FAIL;
                  end
               end
               default: begin
                  cmd.op = OP_FAIL;
               end
            endcase
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               cmd.op   = OP_PICK_READ;
               state_in = ST_PICK_CAP;
            end
         end
         ST_PICK_CAP: begin
            cmd.op   = OP_PICK_CAPTURE;
            state_in = ST_RESP;
         end
         ST_SW_B: begin
            cmd.op   = OP_SW_READ_PART;
            state_in = ST_SW_C;
         end
         ST_SW_C: begin
            cmd.op   = OP_SW_WRITE_POS;
            state_in = ST_SW_D;
         end
         ST_SW_D: begin
            cmd.op   = OP_SW_WRITE_PART;
            state_in = (status.action == ACT_ACCEPT) ? ST_ROT_CHECK : ST_RESP;
         end
         ST_ROT_CHECK: begin
            // Each pass rotates the recent region left by one and shrinks it.
            if (!status.rot_needed) begin
               state_in = ST_RESP;
            end else if (status.rot_single) begin
               cmd.op = OP_ROT_DEC;
            end else begin
               cmd.op   = OP_ROT_READ_HEAD;
               state_in = ST_ROT_SAVE;
            end
         end
         ST_ROT_SAVE: begin
            cmd.op   = OP_ROT_SAVE;
            state_in = ST_ROT_SHIFT;
         end
         ST_ROT_SHIFT: begin
            cmd.op = OP_ROT_SHIFT;
            if (status.rot_last) begin
               state_in = ST_ROT_TAIL;
            end
         end
         ST_ROT_TAIL: begin
            cmd.op   = OP_ROT_TAIL;
            state_in = ST_ROT_CHECK;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/rerp_checker.sv
// Port-level checker for the picker top level, with its bind statement.
module rerp_checker #(
   parameter int TABLE_DEPTH = rerp_pkg::TABLE_DEPTH_DEF,
   parameter int ENTRY_BITS  = rerp_pkg::ENTRY_BITS_DEF,
   localparam int POS_W      = $clog2(TABLE_DEPTH),
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_ok,
   input logic [POS_W-1:0]      rsp_position_out,
   input logic [ENTRY_BITS-1:0] rsp_entry_out,
   input logic [CNT_W-1:0]      rsp_recent_count,
   input logic [CNT_W-1:0]      rsp_rejected_count
);
   import rerp_pkg::*;

   logic [CNT_W:0] region_sum;

   assign region_sum = (CNT_W+1)'(rsp_recent_count) + (CNT_W+1)'(rsp_rejected_count);

   // A stalled result word holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
         && $stable(rsp_position_out) && $stable(rsp_entry_out)
         && $stable(rsp_recent_count) && $stable(rsp_rejected_count))
      else $error("result word changed while stalled");

   // A failed command reports no position and no entry.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_position_out == '0 && rsp_entry_out == '0)
      else $error("failed command carries a position or entry");

   // The recent and rejected regions never overlap past the table.
   a_region_fit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> region_sum <= (CNT_W+1)'(TABLE_DEPTH))
      else $error("region counts exceed table depth");

   // Only one command is in flight at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while one is in flight");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind recency_excluding_random_picker_top rerp_checker #(
   .TABLE_DEPTH (TABLE_DEPTH),
   .ENTRY_BITS  (ENTRY_BITS)
) u_rerp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_ok             (rsp_ok),
   .rsp_position_out   (rsp_position_out),
   .rsp_entry_out      (rsp_entry_out),
   .rsp_recent_count   (rsp_recent_count),
   .rsp_rejected_count (rsp_rejected_count)
);
